// File: rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`endif

// File: rtl/gdn_pkg.sv
// Shared types and constants of the grid node neighbor index block.
package gdn_pkg;

   localparam int IDX_W      = 32;
   localparam int SIZE_W     = 11;
   localparam int SXY_W      = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = IDX_W / DIV_BITS;

   localparam logic [IDX_W-1:0] OFF_GRID_IDX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 2'd2;

   localparam int NB_LEFT  = 0;
   localparam int NB_RIGHT = 1;
   localparam int NB_DOWN  = 2;
   localparam int NB_UP    = 3;
   localparam int NB_BACK  = 4;
   localparam int NB_FRONT = 5;
   localparam int NB_COUNT = 6;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
      logic [SXY_W-1:0]  size_xy;
   } cfg_type;

endpackage

// File: rtl/grid_node_neighbor_indices.sv
// Top level of the 3D grid six-neighbor index block.
//
// Usage: program size_x, size_y and size_z (csr indices 0, 1, 2) while no
// transaction is in flight; a size of 0 is held as 1, above MAX_SIZE as
// MAX_SIZE, and writes to index 3 are dropped. Then present a linear node
// index on req_node_index with start high; it is taken on any edge where
// busy is low. The six face-neighbor indices (-x, +x, -y, +y, -z, +z, all
// ones where off the grid) appear together for one cycle with rsp_strobe.
// The path from the accepting edge to the result runs through three
// pipelined 32-by-11-bit dividers of 8 stages each (4 quotient bits per
// stage) for x, y and z, then 3 stages that multiply, add and form the
// neighbors. Throughput is one transaction per cycle.
// Reset clears all valid bits, sets every size to 1 and holds busy high
// until the cycle after reset drops. The receiver cannot stall, so the
// pipeline never waits.
module grid_node_neighbor_indices #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gdn_pkg::IDX_W-1:0]     req_node_index,
   output logic                          rsp_strobe,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_left_neighbor,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_right_neighbor,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_down_neighbor,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_up_neighbor,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_back_neighbor,
   output logic [gdn_pkg::IDX_W-1:0]     rsp_front_neighbor,
   input  logic                          csr_wr_en,
   input  logic [gdn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gdn_pkg::SIZE_W-1:0]    csr_wdata
);
   import gdn_pkg::*;

   `include "assert_macros.svh"

   localparam int CW      = $clog2(MAX_SIZE);
   localparam int LATENCY = 3 * DIV_STAGES + 3;

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE);
   localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

   function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_ONE;
      end else if (v > SIZE_MAX) begin
         r = SIZE_MAX;
      end
      return r;
   endfunction

   // Configuration
   logic              busy_ff;
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SXY_W-1:0]  size_xy_ff, size_xy_in;
   logic [2*SIZE_W-1:0] size_xy_full;
   cfg_type           cfg;

   assign size_xy_full = (2*SIZE_W)'(size_x_ff) * (2*SIZE_W)'(size_y_ff);
   assign size_xy_in   = size_xy_full[SXY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         size_x_ff  <= SIZE_ONE;
         size_y_ff  <= SIZE_ONE;
         size_z_ff  <= SIZE_ONE;
         size_xy_ff <= SXY_W'(1);
      end else begin
         busy_ff    <= 1'b0;
         size_xy_ff <= size_xy_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_SIZE_X: size_x_ff <= clamp_size(csr_wdata);
               REG_SIZE_Y: size_y_ff <= clamp_size(csr_wdata);
               REG_SIZE_Z: size_z_ff <= clamp_size(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;
   assign cfg  = '{size_x: size_x_ff, size_y: size_y_ff, size_z: size_z_ff,
                   size_xy: size_xy_ff};

   logic accept;
   assign accept = start && !busy_ff;

   // x = idx mod sx, q1 = idx div sx
   logic             d1_valid;
   logic [IDX_W-1:0] d1_quot;
   logic [CW-1:0]    d1_x;
   logic             d1_side;

   gdn_div_pipe #(.SIDE_W(1), .REM_W(CW)) u_div_x (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_dividend   (req_node_index),
      .divisor       (size_x_ff),
      .in_side       (1'b0),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_x),
      .out_side      (d1_side)
   );

   // y = q1 mod sy, q2 = q1 div sy
   logic             d2_valid;
   logic [IDX_W-1:0] d2_quot;
   logic [CW-1:0]    d2_y;
   logic [CW-1:0]    d2_x;

   gdn_div_pipe #(.SIDE_W(CW), .REM_W(CW)) u_div_y (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_dividend   (d1_quot),
      .divisor       (size_y_ff),
      .in_side       (d1_x),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_y),
      .out_side      (d2_x)
   );

   // z = q2 mod sz; the quotient here is not needed
   logic             d3_valid;
   logic [IDX_W-1:0] d3_quot;
   logic [CW-1:0]    d3_z;
   logic [2*CW-1:0]  d3_side;

   gdn_div_pipe #(.SIDE_W(2*CW), .REM_W(CW)) u_div_z (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d2_valid),
      .in_dividend   (d2_quot),
      .divisor       (size_z_ff),
      .in_side       ({d2_y, d2_x}),
      .out_valid     (d3_valid),
      .out_quotient  (d3_quot),
      .out_remainder (d3_z),
      .out_side      (d3_side)
   );

   gdn_link #(.CW(CW)) u_link (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (d3_valid),
      .in_x       (d3_side[CW-1:0]),
      .in_y       (d3_side[2*CW-1:CW]),
      .in_z       (d3_z),
      .out_strobe (rsp_strobe),
      .out_left   (rsp_left_neighbor),
      .out_right  (rsp_right_neighbor),
      .out_down   (rsp_down_neighbor),
      .out_up     (rsp_up_neighbor),
      .out_back   (rsp_back_neighbor),
      .out_front  (rsp_front_neighbor)
   );

   logic x_pair_seen;
   logic x_pair_apart;
   logic sizes_legal;

   assign x_pair_seen  = rsp_strobe && (rsp_left_neighbor != OFF_GRID_IDX)
                         && (rsp_right_neighbor != OFF_GRID_IDX);
   assign x_pair_apart = (rsp_right_neighbor == rsp_left_neighbor + IDX_W'(2));
   assign sizes_legal  = (size_x_ff != '0) && (size_x_ff <= SIZE_MAX)
                         && (size_y_ff != '0) && (size_y_ff <= SIZE_MAX)
                         && (size_z_ff != '0) && (size_z_ff <= SIZE_MAX);

   // Every result traces back to an accepted transaction.
   `ASSERT_IMPL(a_result_latency, clock, reset, rsp_strobe, $past(accept, LATENCY))

   // Both x neighbors present means they sit two apart.
   `ASSERT_IMPL(a_x_pair, clock, reset, x_pair_seen, x_pair_apart)

   // Sizes stay clamped to the legal range.
   `ASSERT_ALWAYS(a_size_range, clock, reset, sizes_legal)

   // Unused divider outputs: the side data of the first and the quotient of the last.
   logic unused_ok;
   assign unused_ok = d1_side ^ (^d3_quot);

endmodule

// File: rtl/gdn_div_pipe.sv
// Pipelined restoring divider: 32-bit dividend by an 11-bit divisor, side data carried along.
module gdn_div_pipe #(
   parameter int SIDE_W = 1,
   parameter int REM_W  = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [gdn_pkg::IDX_W-1:0]   in_dividend,
   input  logic [gdn_pkg::SIZE_W-1:0]  divisor,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [gdn_pkg::IDX_W-1:0]   out_quotient,
   output logic [REM_W-1:0]            out_remainder,
   output logic [SIDE_W-1:0]           out_side
);
   import gdn_pkg::*;

   typedef struct packed {
      logic [SIZE_W-1:0] rem;
      logic [IDX_W-1:0]  work;
   } div_state_type;

   // Shift dividend bits into the remainder, quotient bits into the freed low end.
   function automatic div_state_type div_steps(div_state_type s, logic [SIZE_W-1:0] d);
      div_state_type r;
      logic [SIZE_W:0] trial;
      r = s;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial  = {r.rem, r.work[IDX_W-1]};
         r.work = {r.work[IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            trial     = trial - {1'b0, d};
            r.work[0] = 1'b1;
         end
         r.rem = trial[SIZE_W-1:0];
      end
      return r;
   endfunction

   logic          valid_ff [DIV_STAGES];
   div_state_type st_ff    [DIV_STAGES];
   logic [SIDE_W-1:0] side_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_state_type     src;
      div_state_type     st_in;
      logic              src_valid;
      logic [SIDE_W-1:0] src_side;

      if (s == 0) begin : g_first
         assign src       = '{rem: '0, work: in_dividend};
         assign src_valid = in_valid;
         assign src_side  = in_side;
      end else begin : g_next
         assign src       = st_ff[s-1];
         assign src_valid = valid_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      assign st_in = div_steps(src, divisor);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= src_valid;
         end
         st_ff[s]   <= st_in;
         side_ff[s] <= src_side;
      end
   end

   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_quotient  = st_ff[DIV_STAGES-1].work;
   assign out_remainder = st_ff[DIV_STAGES-1].rem[REM_W-1:0];
   assign out_side      = side_ff[DIV_STAGES-1];

endmodule

// File: rtl/gdn_link.sv
// Neighbor builder: coordinates to base index, then six neighbor indices with edge checks.
module gdn_link #(
   parameter int CW = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gdn_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   input  logic [CW-1:0]              in_x,
   input  logic [CW-1:0]              in_y,
   input  logic [CW-1:0]              in_z,
   output logic                       out_strobe,
   output logic [gdn_pkg::IDX_W-1:0]  out_left,
   output logic [gdn_pkg::IDX_W-1:0]  out_right,
   output logic [gdn_pkg::IDX_W-1:0]  out_down,
   output logic [gdn_pkg::IDX_W-1:0]  out_up,
   output logic [gdn_pkg::IDX_W-1:0]  out_back,
   output logic [gdn_pkg::IDX_W-1:0]  out_front
);
   import gdn_pkg::*;

   localparam int YP_W = CW + SIZE_W;
   localparam int ZP_W = CW + SXY_W;

   // Stage A: products and edge flags
   logic                a_valid_ff;
   logic [CW-1:0]       a_x_ff;
   logic [YP_W-1:0]     a_ysx_ff, a_ysx_in;
   logic [ZP_W-1:0]     a_zsxy_ff, a_zsxy_in;
   logic [NB_COUNT-1:0] a_has_ff, a_has_in;

   assign a_ysx_in  = YP_W'(in_y) * YP_W'(cfg.size_x);
   assign a_zsxy_in = ZP_W'(in_z) * ZP_W'(cfg.size_xy);

   always_comb begin
      a_has_in           = '0;
      a_has_in[NB_LEFT]  = (in_x != '0);
      a_has_in[NB_RIGHT] = ((SIZE_W'(in_x) + SIZE_W'(1)) < cfg.size_x);
      a_has_in[NB_DOWN]  = (in_y != '0);
      a_has_in[NB_UP]    = ((SIZE_W'(in_y) + SIZE_W'(1)) < cfg.size_y);
      a_has_in[NB_BACK]  = (in_z != '0);
      a_has_in[NB_FRONT] = ((SIZE_W'(in_z) + SIZE_W'(1)) < cfg.size_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_x_ff    <= in_x;
      a_ysx_ff  <= a_ysx_in;
      a_zsxy_ff <= a_zsxy_in;
      a_has_ff  <= a_has_in;
   end

   // Stage B: base index of the node
   logic                b_valid_ff;
   logic [IDX_W-1:0]    b_base_ff, b_base_in;
   logic [NB_COUNT-1:0] b_has_ff;

   assign b_base_in = IDX_W'(a_x_ff) + IDX_W'(a_ysx_ff) + IDX_W'(a_zsxy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_base_ff <= b_base_in;
      b_has_ff  <= a_has_ff;
   end

   // Stage C: offsets, sentinel where the neighbor is off the grid
   logic             c_strobe_ff;
   logic [IDX_W-1:0] c_left_ff, c_left_in;
   logic [IDX_W-1:0] c_right_ff, c_right_in;
   logic [IDX_W-1:0] c_down_ff, c_down_in;
   logic [IDX_W-1:0] c_up_ff, c_up_in;
   logic [IDX_W-1:0] c_back_ff, c_back_in;
   logic [IDX_W-1:0] c_front_ff, c_front_in;

   assign c_left_in  = b_has_ff[NB_LEFT]  ? b_base_ff - IDX_W'(1) : OFF_GRID_IDX;
   assign c_right_in = b_has_ff[NB_RIGHT] ? b_base_ff + IDX_W'(1) : OFF_GRID_IDX;
   assign c_down_in  = b_has_ff[NB_DOWN]  ? b_base_ff - IDX_W'(cfg.size_x) : OFF_GRID_IDX;
   assign c_up_in    = b_has_ff[NB_UP]    ? b_base_ff + IDX_W'(cfg.size_x) : OFF_GRID_IDX;
   assign c_back_in  = b_has_ff[NB_BACK]  ? b_base_ff - IDX_W'(cfg.size_xy) : OFF_GRID_IDX;
   assign c_front_in = b_has_ff[NB_FRONT] ? b_base_ff + IDX_W'(cfg.size_xy) : OFF_GRID_IDX;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_strobe_ff <= 1'b0;
      end else begin
         c_strobe_ff <= b_valid_ff;
      end
      c_left_ff  <= c_left_in;
      c_right_ff <= c_right_in;
      c_down_ff  <= c_down_in;
      c_up_ff    <= c_up_in;
      c_back_ff  <= c_back_in;
      c_front_ff <= c_front_in;
   end

   assign out_strobe = c_strobe_ff;
   assign out_left   = c_left_ff;
   assign out_right  = c_right_ff;
   assign out_down   = c_down_ff;
   assign out_up     = c_up_ff;
   assign out_back   = c_back_ff;
   assign out_front  = c_front_ff;

endmodule
